// File: rtl/task_slot_and_runqueue_dispatcher_core_macros.svh
// Assertion helpers shared by the dispatcher RTL.
`ifndef TASK_SLOT_AND_RUNQUEUE_DISPATCHER_CORE_MACROS_SVH
`define TASK_SLOT_AND_RUNQUEUE_DISPATCHER_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define TSRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dispatcher check failed");

// Next-cycle implication, switched off while reset is high.
`define TSRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dispatcher check failed");

`endif

// File: rtl/tsrd_pkg.sv
package tsrd_pkg;

   // Default sizes of the slot table and of the CPU set.
   localparam int DEFAULT_NUM_TASKS = 64;
   localparam int DEFAULT_NUM_CPUS  = 8;

   // Fixed widths of the port fields.
   localparam int CFG_W        = 4;
   localparam int SLOT_FIELD_W = 6;
   localparam int CPU_FIELD_W  = 3;
   localparam int POS_FIELD_W  = 6;
   localparam int STATUS_W     = 2;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd1;

   // Request opcodes.
   localparam logic OP_CREATE = 1'b0;
   localparam logic OP_KILL   = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_NO_SLOT = 2'd1,
      STATUS_REJECT  = 2'd2
   } status_type;

   // Request sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMMIT
   } state_type;

   // Strobes from the sequencer to the datapath.
   typedef struct packed {
      logic stall;
      logic lookup;
      logic commit;
   } ctrl_type;

endpackage

// File: rtl/tsrd_cpu_select.sv
module tsrd_cpu_select
   import tsrd_pkg::*;
#(
   parameter int NUM_CPUS = DEFAULT_NUM_CPUS,
   parameter int LEN_W    = $clog2(DEFAULT_NUM_TASKS + 1),
   parameter int CPU_W    = $clog2(DEFAULT_NUM_CPUS)
) (
   input  logic [LEN_W-1:0] queue_len [NUM_CPUS],
   input  logic [CFG_W-1:0] cpus_in_use,
   output logic [CPU_W-1:0] best_cpu,
   output logic [LEN_W-1:0] best_len
);

   localparam int LEVELS = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int LEAVES = 2 ** LEVELS;

   // One extra key bit lets CPUs that are not in use sort above every real length.
   logic [LEN_W:0]   key [LEVELS+1][LEAVES];
   logic [CPU_W-1:0] idx [LEVELS+1][LEAVES];

   // Tournament tree over the queue lengths. The left side wins a tie, so the
   // lowest CPU index among the shortest queues comes out at the root.
   always_comb begin
      for (int l = 0; l <= LEVELS; l++) begin
         for (int n = 0; n < LEAVES; n++) begin
            key[l][n] = '1;
            idx[l][n] = '0;
         end
      end
      // CPU 0 is always in use; a register value of zero acts as one.
      for (int n = 0; n < LEAVES; n++) begin
         if (n < NUM_CPUS) begin
            if (n == 0 || n < int'(cpus_in_use)) begin
               key[0][n] = {1'b0, queue_len[n]};
            end
         end
         idx[0][n] = CPU_W'(n);
      end
      for (int l = 0; l < LEVELS; l++) begin
         for (int n = 0; n < (LEAVES >> (l + 1)); n++) begin
            if (key[l][2*n+1] < key[l][2*n]) begin
               key[l+1][n] = key[l][2*n+1];
               idx[l+1][n] = idx[l][2*n+1];
            end else begin
               key[l+1][n] = key[l][2*n];
               idx[l+1][n] = idx[l][2*n];
            end
         end
      end
   end

   assign best_cpu = idx[LEVELS][0];
   assign best_len = key[LEVELS][0][LEN_W-1:0];

endmodule

// File: rtl/task_slot_and_runqueue_dispatcher_core.sv
// Sequence: a request beat is taken in the idle state, and the lookup and commit states follow.
// The result is loaded into the rsp register at the commit; no new beat is taken before then.
// Slot table read and run queue read sit back to back; a stalled rsp holds the commit.
// Reset: all slots free, all run queues empty, cpus_in_use back to 1. The memories are not
// swept, as the data of an unwritten entry is never used; requests are taken at once.
`include "task_slot_and_runqueue_dispatcher_core_macros.svh"

module task_slot_and_runqueue_dispatcher_core
   import tsrd_pkg::*;
#(
   parameter int NUM_TASKS = DEFAULT_NUM_TASKS,
   parameter int NUM_CPUS  = DEFAULT_NUM_CPUS
) (
   input  logic                    clock,
   input  logic                    reset,
   // Request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_opcode,
   input  logic [SLOT_FIELD_W-1:0] req_target_task,
   input  logic [CPU_FIELD_W-1:0]  req_requester_cpu,
   // Result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [SLOT_FIELD_W-1:0] rsp_task_slot,
   output logic [CPU_FIELD_W-1:0]  rsp_chosen_cpu,
   output logic [POS_FIELD_W-1:0]  rsp_queue_position,
   // Configuration write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CFG_W-1:0]        csr_cpus_in_use
);

   localparam int SLOT_W   = $clog2(NUM_TASKS);
   localparam int CPU_W    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int LEN_W    = $clog2(NUM_TASKS + 1);
   localparam int INFO_W   = CPU_W + SLOT_W;
   localparam int RQ_AW    = CPU_W + SLOT_W;
   localparam int RQ_DEPTH = 2 ** RQ_AW;

   // Control state
   state_type state_ff, state_in;
   ctrl_type  ctrl;
   logic      accept;
   logic      out_free;

   logic [CFG_W-1:0] cpus_cfg_ff;
   logic [NUM_TASKS-1:0] slot_used_ff;
   logic [LEN_W-1:0] queue_len_ff [NUM_CPUS];

   // Memories: per-slot owner CPU and queue position, and the run queues.
   logic [INFO_W-1:0] slot_info_mem [NUM_TASKS];
   logic [SLOT_W-1:0] run_queue_mem [RQ_DEPTH];
   logic [INFO_W-1:0] slot_info_rd_ff;
   logic [SLOT_W-1:0] rq_rd_ff;

   // Request held for the duration of its work
   logic                    opcode_ff;
   logic [SLOT_FIELD_W-1:0] target_ff;
   logic [CPU_FIELD_W-1:0]  requester_ff;

   // Create path
   logic              free_found;
   logic [SLOT_W-1:0] free_slot;
   logic [CPU_W-1:0]  best_cpu;
   logic [LEN_W-1:0]  best_len;
   logic              free_found_ff;
   logic [SLOT_W-1:0] free_slot_ff;
   logic [CPU_W-1:0]  best_cpu_ff;
   logic [LEN_W-1:0]  best_len_ff;

   // Kill path
   logic [SLOT_W-1:0] req_tgt_idx;
   logic [SLOT_W-1:0] tgt_idx;
   logic [CPU_W-1:0]  req_idx;
   logic [CPU_W-1:0]  info_cpu;
   logic [SLOT_W-1:0] info_pos;
   logic [LEN_W-1:0]  req_len;
   logic              kill_ok;
   logic [SLOT_W-1:0] kill_last;
   logic [SLOT_W-1:0] kill_pos;
   logic              kill_ok_ff;
   logic [SLOT_W-1:0] kill_last_ff;
   logic [SLOT_W-1:0] kill_pos_ff;

   // Memory write ports
   logic              si_we;
   logic [SLOT_W-1:0] si_waddr;
   logic [INFO_W-1:0] si_wdata;
   logic              rq_we;
   logic [RQ_AW-1:0]  rq_waddr;
   logic [SLOT_W-1:0] rq_wdata;

   // Result register
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [CPU_FIELD_W-1:0]  rsp_cpu_ff, rsp_cpu_in;
   logic [POS_FIELD_W-1:0]  rsp_pos_ff, rsp_pos_in;

   // Commit strobes watched by the checks.
   logic kill_commit;
   logic create_commit;

   // Configuration register; writes are taken whenever reset is low.
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpus_cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         cpus_cfg_ff <= csr_cpus_in_use;
      end
   end

   // Sequencer: next state.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_COMMIT;
         ST_COMMIT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer: strobes.
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:   ctrl.stall = 1'b0;
         ST_LOOKUP: begin
            ctrl.stall  = 1'b1;
            ctrl.lookup = 1'b1;
         end
         ST_COMMIT: begin
            ctrl.stall  = 1'b1;
            ctrl.commit = out_free;
         end
         default:   ctrl.stall = 1'b1;
      endcase
   end

   // No request beat is taken while reset is high.
   assign req_stall = ctrl.stall || reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Lowest free slot, taken from the used bitmap.
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = NUM_TASKS - 1; i >= 0; i--) begin
         if (!slot_used_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   // Shortest queue among the CPUs in use.
   tsrd_cpu_select #(
      .NUM_CPUS (NUM_CPUS),
      .LEN_W    (LEN_W),
      .CPU_W    (CPU_W)
   ) u_cpu_select (
      .queue_len   (queue_len_ff),
      .cpus_in_use (cpus_cfg_ff),
      .best_cpu    (best_cpu),
      .best_len    (best_len)
   );

   // Capture the request and the create choices when the beat is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff     <= req_opcode;
         target_ff     <= req_target_task;
         requester_ff  <= req_requester_cpu;
         free_found_ff <= free_found;
         free_slot_ff  <= free_slot;
         best_cpu_ff   <= best_cpu;
         best_len_ff   <= best_len;
      end
   end

   // Slot table read, addressed straight from the request beat.
   assign req_tgt_idx = SLOT_W'(req_target_task);

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_info_rd_ff <= slot_info_mem[req_tgt_idx];
      end
   end

   // Kill checks on the slot table entry.
   assign tgt_idx  = SLOT_W'(target_ff);
   assign req_idx  = CPU_W'(requester_ff);
   assign info_cpu = slot_info_rd_ff[INFO_W-1 -: CPU_W];
   assign info_pos = slot_info_rd_ff[SLOT_W-1:0];
   assign req_len  = queue_len_ff[req_idx];

   always_comb begin
      kill_ok = (target_ff != '0) && (int'(target_ff) < NUM_TASKS) &&
                (int'(requester_ff) < NUM_CPUS) && slot_used_ff[tgt_idx] &&
                (info_cpu == req_idx) && (req_len != '0);
      kill_last = SLOT_W'(req_len - LEN_W'(1));
      kill_pos  = (info_pos > kill_last) ? kill_last : info_pos;
   end

   always_ff @(posedge clock) begin
      if (ctrl.lookup) begin
         kill_ok_ff   <= kill_ok;
         kill_last_ff <= kill_last;
         kill_pos_ff  <= kill_pos;
      end
   end

   // Run queue read of the tail entry that fills the hole.
   always_ff @(posedge clock) begin
      if (ctrl.lookup) begin
         rq_rd_ff <= run_queue_mem[{req_idx, kill_last}];
      end
   end

   // Write ports: a create appends, a kill moves the tail into the hole.
   always_comb begin
      si_we    = 1'b0;
      si_waddr = free_slot_ff;
      si_wdata = {best_cpu_ff, SLOT_W'(best_len_ff)};
      rq_we    = 1'b0;
      rq_waddr = {best_cpu_ff, SLOT_W'(best_len_ff)};
      rq_wdata = free_slot_ff;
      if (ctrl.commit) begin
         if (opcode_ff == OP_CREATE) begin
            si_we = free_found_ff;
            rq_we = free_found_ff;
         end else if (kill_ok_ff && (kill_pos_ff != kill_last_ff)) begin
            si_we    = 1'b1;
            si_waddr = rq_rd_ff;
            si_wdata = {req_idx, kill_pos_ff};
            rq_we    = 1'b1;
            rq_waddr = {req_idx, kill_pos_ff};
            rq_wdata = rq_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (si_we) begin
         slot_info_mem[si_waddr] <= si_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_we) begin
         run_queue_mem[rq_waddr] <= rq_wdata;
      end
   end

   // Used bitmap and queue lengths.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff <= '0;
         for (int c = 0; c < NUM_CPUS; c++) begin
            queue_len_ff[c] <= '0;
         end
      end else if (ctrl.commit) begin
         if (opcode_ff == OP_CREATE) begin
            if (free_found_ff) begin
               slot_used_ff[free_slot_ff] <= 1'b1;
               queue_len_ff[best_cpu_ff]  <= best_len_ff + LEN_W'(1);
            end
         end else if (kill_ok_ff) begin
            slot_used_ff[tgt_idx] <= 1'b0;
            queue_len_ff[req_idx] <= LEN_W'(kill_last_ff);
         end
      end
   end

   // Result fields.
   always_comb begin
      rsp_status_in = STATUS_DONE;
      rsp_slot_in   = target_ff;
      rsp_cpu_in    = requester_ff;
      rsp_pos_in    = '0;
      if (opcode_ff == OP_CREATE) begin
         if (free_found_ff) begin
            rsp_slot_in = SLOT_FIELD_W'(free_slot_ff);
            rsp_cpu_in  = CPU_FIELD_W'(best_cpu_ff);
            rsp_pos_in  = POS_FIELD_W'(best_len_ff);
         end else begin
            rsp_status_in = STATUS_NO_SLOT;
            rsp_slot_in   = '0;
            rsp_cpu_in    = '0;
         end
      end else if (kill_ok_ff) begin
         rsp_pos_in = POS_FIELD_W'(kill_pos_ff);
      end else begin
         rsp_status_in = STATUS_REJECT;
      end
   end

   // Result register; it holds while the far side stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_cpu_ff    <= rsp_cpu_in;
         rsp_pos_ff    <= rsp_pos_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_task_slot      = rsp_slot_ff;
   assign rsp_chosen_cpu     = rsp_cpu_ff;
   assign rsp_queue_position = rsp_pos_ff;

   // Checks on the sequencing and on the table updates.
   assign kill_commit   = ctrl.commit && (opcode_ff == OP_KILL) && kill_ok_ff;
   assign create_commit = ctrl.commit && (opcode_ff == OP_CREATE) && free_found_ff;

   `TSRD_ASSERT_NEXT(a_accept_to_lookup, clock, reset, accept, state_ff == ST_LOOKUP)
   `TSRD_ASSERT_NEXT(a_kill_shortens_queue, clock, reset, kill_commit, req_len == $past(req_len) - LEN_W'(1))
   `TSRD_ASSERT_NEXT(a_create_marks_used, clock, reset, create_commit, slot_used_ff[free_slot_ff])
   `TSRD_ASSERT_IMPL(a_rsp_from_commit, clock, reset, $rose(rsp_valid_ff), $past(ctrl.commit))

endmodule
